[src/psh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_pkg: shared types and constants for the polynomial string hasher
// Widths, the prime modulus and the constant reduction table used by the
// absorb logic and the top level.
// ----------------------------------------------------------------------------
package psh_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int HASH_WIDTH = 40;
   localparam int LO_WIDTH   = 32;
   localparam int HI_WIDTH   = HASH_WIDTH - LO_WIDTH;
   // worst case sum before correction stays below 3 * modulus < 2^42
   localparam int SUM_WIDTH  = HASH_WIDTH + 2;

   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [HASH_WIDTH-1:0] hash_type;
   typedef logic [SUM_WIDTH-1:0]  sum_type;
   typedef logic [HI_WIDTH-1:0]   hi_type;
   typedef logic [LO_WIDTH-1:0]   lo_type;

   localparam hash_type HASH_MODULUS = 40'd1000000005721;

   // (263 * 2^32) mod modulus: weight of one step of the top accumulator byte
   localparam logic [63:0] HI_STEP_WIDE = (64'd263 << LO_WIDTH) % 64'd1000000005721;
   localparam hash_type    HI_STEP      = HI_STEP_WIDE[HASH_WIDTH-1:0];

   typedef hash_type hi_table_type [2**HI_WIDTH];

   // entry i = (i * 263 * 2^32) mod modulus, built by repeated modular add
   function automatic hi_table_type build_hi_table();
      hi_table_type          tbl;
      logic [HASH_WIDTH:0]   run;
      run = '0;
      for (int i = 0; i < 2**HI_WIDTH; i++) begin
         tbl[i] = run[HASH_WIDTH-1:0];
         run = run + {1'b0, HI_STEP};
         if (run >= {1'b0, HASH_MODULUS}) begin
            run = run - {1'b0, HASH_MODULUS};
         end
      end
      return tbl;
   endfunction

   localparam hi_table_type HI_TABLE = build_hi_table();

   typedef struct packed {
      byte_type byte_value;
      logic     last_byte;
      logic     end_without_byte;
   } req_item_type;

endpackage

[src/psh_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_req_if: byte input channel
// Valid/ready channel carrying one string byte and its closing flags per beat.
// ----------------------------------------------------------------------------
interface psh_req_if;
   logic                valid;
   logic                ready;
   psh_pkg::byte_type   byte_value;
   logic                last_byte;
   logic                end_without_byte;

   modport source (output valid, output byte_value, output last_byte,
                   output end_without_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte,
                   input end_without_byte, output ready);
endinterface

[src/psh_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_rsp_if: hash result channel
// Valid/ready channel carrying one finished string hash per beat.
// ----------------------------------------------------------------------------
interface psh_rsp_if;
   logic                valid;
   logic                ready;
   psh_pkg::hash_type   hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

[src/psh_absorb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_absorb: one Horner step modulo the prime
// next = (acc * 263 + byte) mod 1000000005721, for acc already reduced.
// ----------------------------------------------------------------------------
module psh_absorb (
   input  psh_pkg::hash_type acc,
   input  psh_pkg::byte_type byte_value,
   output psh_pkg::hash_type next_hash
);

   psh_pkg::hi_type  acc_hi;
   psh_pkg::lo_type  acc_lo;
   psh_pkg::sum_type lo_ext;
   psh_pkg::sum_type sum;
   psh_pkg::sum_type mod1;
   psh_pkg::sum_type mod2;
   psh_pkg::sum_type diff1;
   psh_pkg::sum_type diff2;
   psh_pkg::sum_type picked;

   assign acc_hi = acc[psh_pkg::HASH_WIDTH-1:psh_pkg::LO_WIDTH];
   assign acc_lo = acc[psh_pkg::LO_WIDTH-1:0];
   assign lo_ext = psh_pkg::sum_type'(acc_lo);

   // top byte goes through the pre-reduced table, low word times 263 = 256+4+2+1
   assign sum = psh_pkg::sum_type'(psh_pkg::HI_TABLE[acc_hi])
              + (lo_ext << 8) + (lo_ext << 2) + (lo_ext << 1) + lo_ext
              + psh_pkg::sum_type'(byte_value);

   assign mod1  = psh_pkg::sum_type'(psh_pkg::HASH_MODULUS);
   assign mod2  = mod1 << 1;
   assign diff1 = sum - mod1;
   assign diff2 = sum - mod2;

   always_comb begin
      if (sum >= mod2) begin
         picked = diff2;
      end else if (sum >= mod1) begin
         picked = diff1;
      end else begin
         picked = sum;
      end
   end

   assign next_hash = picked[psh_pkg::HASH_WIDTH-1:0];

endmodule

[src/psh_result_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_result_reg: output register for finished hashes
// Holds one result beat; frees in the same cycle the sink takes it.
// ----------------------------------------------------------------------------
module psh_result_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  psh_pkg::hash_type push_hash,
   output logic              free,
   psh_rsp_if.source         rsp_bus
);

   logic              valid_ff;
   logic              valid_in;
   psh_pkg::hash_type hash_ff;
   psh_pkg::hash_type hash_in;

   assign free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      hash_in  = hash_ff;
      if (push) begin
         valid_in = 1'b1;
         hash_in  = push_hash;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.hash_value = hash_ff;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      push |-> free)
      else $error("result pushed while output register still held");

   a_hash_in_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (hash_ff < psh_pkg::HASH_MODULUS))
      else $error("presented hash not reduced");

endmodule

[src/polynomial_string_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_string_hasher: polynomial hash of a byte string mod a prime
// Accepts one byte per beat, last character first, and returns the hash
// (acc * 263 + byte) mod 1000000005721 when a beat closes the string.
// ----------------------------------------------------------------------------
// Bytes stream in at one beat per clock. A beat lands in the input register,
// and in the next cycle the absorb logic (a 256-entry constant table read, a
// six-term add and two parallel compare/subtracts) updates the 40-bit
// accumulator; that accumulator loop sets the rate of one byte per cycle.
// A beat with last_byte adds its byte and then closes the string; a beat
// with end_without_byte closes it without a byte and wins over last_byte. A
// closing beat loads the result register as it leaves the input register and
// clears the accumulator, so the next string may follow in the next cycle.
// An empty string hashes to 0. Results never exceed 40 bits, so the top-bit
// fold of the scheme has no effect and is not built. The input side stalls
// only when a closing beat finds the result register full and not drained.
// ----------------------------------------------------------------------------
module polynomial_string_hasher (
   input  logic        clock,
   input  logic        reset,
   psh_req_if.sink     req_bus,
   psh_rsp_if.source   rsp_bus
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   psh_pkg::req_item_type in_item_ff;
   psh_pkg::req_item_type in_item_in;
   psh_pkg::hash_type     acc_ff;
   psh_pkg::hash_type     acc_in;

   psh_pkg::hash_type     absorbed;
   psh_pkg::hash_type     result_hash;
   logic                  emits;
   logic                  out_free;
   logic                  stage_go;
   logic                  push;
   logic                  req_take;

   assign emits    = in_item_ff.last_byte || in_item_ff.end_without_byte;
   assign stage_go = in_valid_ff && (!emits || out_free);
   assign push     = stage_go && emits;

   assign req_bus.ready = !in_valid_ff || stage_go;
   assign req_take      = req_bus.valid && req_bus.ready;

   psh_absorb u_absorb (
      .acc        (acc_ff),
      .byte_value (in_item_ff.byte_value),
      .next_hash  (absorbed)
   );

   assign result_hash = in_item_ff.end_without_byte ? acc_ff : absorbed;

   always_comb begin
      acc_in = acc_ff;
      if (stage_go) begin
         acc_in = emits ? '0 : absorbed;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
      if (req_take) begin
         in_item_in.byte_value       = req_bus.byte_value;
         in_item_in.last_byte        = req_bus.last_byte;
         in_item_in.end_without_byte = req_bus.end_without_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   psh_result_reg u_result_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_hash (result_hash),
      .free      (out_free),
      .rsp_bus   (rsp_bus)
   );

   a_acc_reduced : assert property (@(posedge clock) disable iff (reset)
      acc_ff < psh_pkg::HASH_MODULUS)
      else $error("accumulator left unreduced");

   a_close_clears : assert property (@(posedge clock) disable iff (reset)
      push |=> (acc_ff == '0))
      else $error("accumulator not cleared after closing beat");

   a_blocked_holds : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && emits && !out_free) |=> (in_valid_ff && $stable(acc_ff)))
      else $error("closing beat dropped while output blocked");

   a_push_loads : assert property (@(posedge clock) disable iff (reset)
      push |=> (rsp_bus.valid && rsp_bus.hash_value == $past(result_hash)))
      else $error("result register missed a closing beat");

endmodule
